[src/avri_pkg.sv]
// Shared widths, register indexes and inter-module types of the velocity ramp integrator.
`default_nettype none

package avri_pkg;

	localparam int NUM_AXES  = 3;
	localparam int DIR_W     = 18;
	localparam int TICK_W    = 24;
	localparam int CFG_W     = 31;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 3;

	// accel * t, and the Q23.16 product taken from it
	localparam int PROD_W = CFG_W + TICK_W;
	localparam int AT_W   = PROD_W - 16;

	// Register indexes of the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_X     = 3'd0,
		REG_ACCEL_Y     = 3'd1,
		REG_ACCEL_Z     = 3'd2,
		REG_MAX_SPEED_X = 3'd3,
		REG_MAX_SPEED_Y = 3'd4,
		REG_MAX_SPEED_Z = 3'd5
	} cfg_reg_t;

	// Stage loads and the final commit, driven by the top level into every lane.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic commit;
	} avri_ctrl_t;

	// What one lane hands to the merging stage.
	typedef struct packed {
		logic signed [OUT_W-1:0] move;
		logic signed [OUT_W-1:0] speed;
		logic                    rest;
		logic                    vel_nz;
	} lane_res_t;

endpackage

`default_nettype wire

[src/avri_lane.sv]
// One axis of the integrator: multiply pipeline, displacement, velocity update and state.
`default_nettype none

module avri_lane
	import avri_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire avri_ctrl_t               ctrl,
	input  wire logic signed [DIR_W-1:0]  dir,
	input  wire logic        [TICK_W-1:0] tick,
	input  wire logic        [CFG_W-1:0]  accel,
	input  wire logic        [CFG_W-1:0]  max_speed,
	output lane_res_t                     res
);

	localparam int ATT_LO_B = 20;
	localparam int DAT_LO_B = 21;
	localparam int ATT_W    = AT_W + TICK_W;
	localparam int DAT_W    = DIR_W + 1 + (AT_W - DAT_LO_B) + DAT_LO_B;
	localparam int VT_W     = OUT_W + TICK_W + 1;
	localparam int DSTEP_W  = DAT_W - 16;
	localparam int NV_W     = DSTEP_W + 1;
	localparam int CO_W     = AT_W + 2;

	logic signed [OUT_W-1:0] velocity_q;

	// Stage 1: acceleration times tick.
	logic        [PROD_W-1:0] prod_s1;
	logic signed [DIR_W-1:0]  dir_s1;
	logic        [TICK_W-1:0] t_s1;
	logic        [AT_W-1:0]   at_w;

	// Stage 2: partial products.
	logic        [AT_W-1:0]                        at_s2;
	logic        [ATT_LO_B+TICK_W-1:0]             att_lo_s2;
	logic        [AT_W-ATT_LO_B+TICK_W-1:0]        att_hi_s2;
	logic signed [DIR_W+DAT_LO_B:0]                dat_lo_s2;
	logic signed [DIR_W+AT_W-DAT_LO_B:0]           dat_hi_s2;
	logic signed [VT_W-1:0]                        vt_s2;
	logic                                          dnz_s2;

	// Stage 3: combined products.
	logic        [AT_W-1:0]    at_s3;
	logic        [ATT_W-2:0]   half_s3;
	logic signed [DSTEP_W-1:0] dstep_s3;
	logic signed [VT_W-1:0]    vt_s3;
	logic                      dnz_s3;

	logic        [ATT_W-1:0]   att_w;
	logic signed [DAT_W-1:0]   dat_w;

	logic signed [63:0]        sum_w;
	logic signed [47:0]        sh_w;
	logic signed [OUT_W-1:0]   move_w;
	logic signed [NV_W-1:0]    acc_w;
	logic signed [NV_W-1:0]    lim_w;
	logic signed [CO_W-1:0]    dn_w;
	logic signed [CO_W-1:0]    up_w;
	logic signed [OUT_W-1:0]   nv_w;

	assign at_w = prod_s1[PROD_W-1:16];

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			prod_s1 <= PROD_W'(accel) * PROD_W'(tick);
			dir_s1  <= dir;
			t_s1    <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			at_s2     <= at_w;
			att_lo_s2 <= (ATT_LO_B+TICK_W)'(at_w[ATT_LO_B-1:0])
				* (ATT_LO_B+TICK_W)'(t_s1);
			att_hi_s2 <= (AT_W-ATT_LO_B+TICK_W)'(at_w[AT_W-1:ATT_LO_B])
				* (AT_W-ATT_LO_B+TICK_W)'(t_s1);
			dat_lo_s2 <= (DIR_W+DAT_LO_B+1)'(dir_s1)
				* (DIR_W+DAT_LO_B+1)'($signed({1'b0, at_w[DAT_LO_B-1:0]}));
			dat_hi_s2 <= (DIR_W+AT_W-DAT_LO_B+1)'(dir_s1)
				* (DIR_W+AT_W-DAT_LO_B+1)'($signed({1'b0, at_w[AT_W-1:DAT_LO_B]}));
			vt_s2     <= VT_W'(velocity_q) * VT_W'($signed({1'b0, t_s1}));
			dnz_s2    <= (dir_s1 != '0);
		end
	end

	assign att_w = {att_hi_s2, {ATT_LO_B{1'b0}}} + ATT_W'(att_lo_s2);
	assign dat_w = $signed({dat_hi_s2, {DAT_LO_B{1'b0}}}) + DAT_W'(dat_lo_s2);

	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			at_s3    <= at_s2;
			half_s3  <= att_w[ATT_W-1:1];
			dstep_s3 <= dat_w[DAT_W-1:16];
			vt_s3    <= vt_s2;
			dnz_s3   <= dnz_s2;
		end
	end

	// Displacement: floor((v*t + at*t/2) / 2^16), saturated to 32 bits.
	assign sum_w = 64'(vt_s3) + $signed({{(64-ATT_W+1){1'b0}}, half_s3});
	assign sh_w  = sum_w[63:16];

	always_comb begin
		if (sh_w[47:OUT_W-1] != {(48-OUT_W+1){sh_w[47]}}) begin
			move_w = sh_w[47] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		end else begin
			move_w = sh_w[OUT_W-1:0];
		end
	end

	// Velocity update: ramp with clamp, or decay toward zero without overshoot.
	assign acc_w = NV_W'(velocity_q) + NV_W'(dstep_s3);
	assign lim_w = $signed({{(NV_W-CFG_W){1'b0}}, max_speed});
	assign dn_w  = CO_W'(velocity_q) - $signed({2'b00, at_s3});
	assign up_w  = CO_W'(velocity_q) + $signed({2'b00, at_s3});

	always_comb begin
		if (dnz_s3) begin
			if (acc_w > lim_w) begin
				nv_w = OUT_W'(lim_w);
			end else if (acc_w < -lim_w) begin
				nv_w = OUT_W'(-lim_w);
			end else begin
				nv_w = OUT_W'(acc_w);
			end
		end else if (velocity_q > 0) begin
			nv_w = dn_w[CO_W-1] ? '0 : OUT_W'(dn_w);
		end else begin
			nv_w = (up_w > 0) ? '0 : OUT_W'(up_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			velocity_q <= '0;
		end else if (ctrl.commit) begin
			velocity_q <= nv_w;
		end
	end

	assign res.move   = move_w;
	assign res.speed  = nv_w;
	assign res.rest   = !dnz_s3 && (velocity_q == '0);
	assign res.vel_nz = (velocity_q != '0);

endmodule

`default_nettype wire

[src/avri_merge.sv]
// Merging stage: gates the lanes' displacements and holds the result register.
`default_nettype none

module avri_merge
	import avri_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    commit,
	input  wire lane_res_t               lane_res [NUM_AXES],
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output logic signed [OUT_W-1:0]      move_out  [NUM_AXES],
	output logic signed [OUT_W-1:0]      speed_out [NUM_AXES]
);

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] move_q  [NUM_AXES];
	logic signed [OUT_W-1:0] speed_q [NUM_AXES];
	logic                    moving;

	// The block only moves if some axis held a velocity before this transaction.
	always_comb begin
		moving = 1'b0;
		for (int i = 0; i < NUM_AXES; i++) begin
			moving = moving | lane_res[i].vel_nz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				move_q[i]  <= (moving && !lane_res[i].rest) ? lane_res[i].move : '0;
				speed_q[i] <= lane_res[i].speed;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign move_out  = move_q;
	assign speed_out = speed_q;

endmodule

`default_nettype wire

[src/axis_velocity_ramp_integrator_top.sv]
// Top level of the three-axis constant-acceleration velocity ramp integrator.
`default_nettype none

// Each input transaction is one tick: a signed Q2.16 direction per axis and
// an unsigned Q8.16 elapsed time. The block answers with exactly one result
// transaction carrying the displacement v*t + a*t*t/2 (from the velocity held
// before the tick, saturated to 32 bits) and the updated velocity per axis.
// Three identical lanes, one per axis, work side by side and a merging stage
// forces every displacement to zero when no axis was moving, and an axis's
// displacement to zero when it was at rest with a zero direction.
// Ticks are handled one at a time: a tick's result is registered after it
// passes the three-stage multiply pipeline in each lane (acceleration times
// time, then the partial products, then their combination) and the final
// add, clamp and commit into the result register, and the next tick is
// accepted in the cycle after that commit. The velocity state is written at
// that commit, which is why the next tick waits for it. A result that is not
// taken holds the pipeline at its last stage and delays the commit by the
// stall; a new tick is still accepted while a finished result waits, as long
// as the previous tick has committed. Configuration writes are always
// accepted (cfg_ready is tied high); indexes beyond the six registers are
// ignored, and writes must only happen while no tick is in flight.
module axis_velocity_ramp_integrator_top
	import avri_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,

	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DIR_W-1:0]  dir_x,
	input  wire logic signed [DIR_W-1:0]  dir_y,
	input  wire logic signed [DIR_W-1:0]  dir_z,
	input  wire logic        [TICK_W-1:0] tick_seconds,

	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [OUT_W-1:0]       move_x,
	output logic signed [OUT_W-1:0]       move_y,
	output logic signed [OUT_W-1:0]       move_z,
	output logic signed [OUT_W-1:0]       speed_x,
	output logic signed [OUT_W-1:0]       speed_y,
	output logic signed [OUT_W-1:0]       speed_z
);

	// Configuration registers: an acceleration and a maximum speed per axis.
	logic [CFG_W-1:0] accel_q [NUM_AXES];
	logic [CFG_W-1:0] max_q   [NUM_AXES];

	// Occupancy of the three lane stages.
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;

	logic                    in_acc;
	avri_ctrl_t              ctrl;
	logic signed [DIR_W-1:0] dir_a [NUM_AXES];
	lane_res_t               lane_res [NUM_AXES];
	logic signed [OUT_W-1:0] move_a  [NUM_AXES];
	logic signed [OUT_W-1:0] speed_a [NUM_AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				accel_q[i] <= '0;
				max_q[i]   <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACCEL_X:     accel_q[0] <= cfg_data;
				REG_ACCEL_Y:     accel_q[1] <= cfg_data;
				REG_ACCEL_Z:     accel_q[2] <= cfg_data;
				REG_MAX_SPEED_X: max_q[0]   <= cfg_data;
				REG_MAX_SPEED_Y: max_q[1]   <= cfg_data;
				REG_MAX_SPEED_Z: max_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A tick is taken only when no earlier tick is still in the lanes.
	assign in_ready = !(vld_s1 || vld_s2 || vld_s3);
	assign in_acc   = in_valid && in_ready;

	assign ctrl.ld_s1  = in_acc;
	assign ctrl.ld_s2  = vld_s1;
	assign ctrl.ld_s3  = vld_s2;
	// The last stage commits once the result register is free or being emptied.
	assign ctrl.commit = vld_s3 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			if (vld_s2) begin
				vld_s3 <= 1'b1;
			end else if (ctrl.commit) begin
				vld_s3 <= 1'b0;
			end
		end
	end

	assign dir_a[0] = dir_x;
	assign dir_a[1] = dir_y;
	assign dir_a[2] = dir_z;

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		avri_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.dir       (dir_a[g]),
			.tick      (tick_seconds),
			.accel     (accel_q[g]),
			.max_speed (max_q[g]),
			.res       (lane_res[g])
		);
	end

	avri_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (ctrl.commit),
		.lane_res  (lane_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.move_out  (move_a),
		.speed_out (speed_a)
	);

	assign move_x  = move_a[0];
	assign move_y  = move_a[1];
	assign move_z  = move_a[2];
	assign speed_x = speed_a[0];
	assign speed_y = speed_a[1];
	assign speed_z = speed_a[2];

endmodule

`default_nettype wire

[src/avri_checker.sv]
// Port-level checks on the integrator's timing, attached to the top level by bind.
`default_nettype none

module avri_checker
	import avri_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_ready,
	input  wire logic                     out_valid,
	input  wire logic                     out_ready,
	input  wire logic signed [OUT_W-1:0]  move_x,
	input  wire logic signed [OUT_W-1:0]  speed_x
);

	// One tick at a time: after a transaction the input stays closed while the tick moves through the lane stages.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input reopened while a tick was still in flight");

	// With the result register free, the result appears once the tick has passed the lane stages and been committed.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (!out_valid || out_ready) |-> ##4 out_valid)
		else $error("result did not appear four cycles after the tick");

	// A pending result is never replaced before it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(move_x) && $stable(speed_x))
		else $error("pending result changed before it was taken");

	// The input only reopens once the tick's result has been registered.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("input reopened without a registered result");

endmodule

bind axis_velocity_ramp_integrator_top avri_checker u_avri_checker (.*);

`default_nettype wire
